[hdl/oaht_pkg.sv]
// oaht_pkg: constants, codes and controller/datapath interface types
// of the open addressing hash table; no dependencies
`default_nettype none
package oaht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SIZE_W      = 11;
  localparam int KEY_W       = 31;
  localparam int MAG_W       = 31;
  localparam int REV_W       = 34;
  localparam int MCNT_W      = 6;
  localparam int PROD_W      = MAG_W + 32;
  localparam int RECIP_SHIFT = 35;
  localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
  localparam int MARK_W      = 2;
  localparam int RAM_W       = MARK_W + KEY_W;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;

  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_FULL    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] STRAT_LINEAR = 2'd0;
  localparam logic [1:0] STRAT_QUAD   = 2'd1;
  localparam logic [1:0] STRAT_DOUBLE = 2'd2;

  localparam logic REG_TABLE_SIZE     = 1'b0;
  localparam logic REG_PROBE_STRATEGY = 1'b1;

  typedef struct packed {
    logic clr;
    logic req_load;
    logic mod_step;
    logic kfin;
    logic rmul;
    logic racc;
    logic rmod_load;
    logic rfin;
    logic probe_init;
    logic probe_chk;
    logic result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic mag_zero;
    logic op_ignore;
    logic strat_dbl;
    logic probe_stop;
    logic probe_last;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

[hdl/oaht_ram.sv]
// oaht_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[hdl/oaht_ctrl.sv]
// oaht_ctrl: sequencing state machine of the hash table
// depends on oaht_pkg
`default_nettype none
module oaht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire oaht_pkg::dp_sts_t sts,
  output oaht_pkg::dp_cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_KMOD  = 12'b0000_0000_0100,
    S_KFIN  = 12'b0000_0000_1000,
    S_RMUL  = 12'b0000_0001_0000,
    S_RACC  = 12'b0000_0010_0000,
    S_RMOD  = 12'b0000_0100_0000,
    S_RFIN  = 12'b0000_1000_0000,
    S_PINIT = 12'b0001_0000_0000,
    S_PRD   = 12'b0010_0000_0000,
    S_PCHK  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_KMOD;
        end
      end
      S_KMOD: begin
        if (sts.mod_done) state_nxt = S_KFIN;
        else cmd.mod_step = 1'b1;
      end
      S_KFIN: begin
        cmd.kfin = 1'b1;
        if (sts.op_ignore) state_nxt = S_DONE;
        else if (sts.strat_dbl) state_nxt = S_RMUL;
        else state_nxt = S_PINIT;
      end
      S_RMUL: begin
        if (sts.mag_zero) begin
          cmd.rmod_load = 1'b1;
          state_nxt     = S_RMOD;
        end else begin
          cmd.rmul  = 1'b1;
          state_nxt = S_RACC;
        end
      end
      S_RACC: begin
        cmd.racc  = 1'b1;
        state_nxt = S_RMUL;
      end
      S_RMOD: begin
        if (sts.mod_done) state_nxt = S_RFIN;
        else cmd.mod_step = 1'b1;
      end
      S_RFIN: begin
        cmd.rfin  = 1'b1;
        state_nxt = S_PINIT;
      end
      S_PINIT: begin
        cmd.probe_init = 1'b1;
        state_nxt      = S_PRD;
      end
      S_PRD: begin
        // slot ram read in flight
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        cmd.probe_chk = 1'b1;
        if (sts.probe_stop || sts.probe_last) state_nxt = S_DONE;
        else state_nxt = S_PRD;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/oaht_dp.sv]
// oaht_dp: datapath of the hash table: config registers, remainder unit,
// digit reversal, probe walk, slot ram and output register; uses oaht_pkg, oaht_ram
`default_nettype none
module oaht_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [oaht_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic                               cfg_addr,
  input  wire logic [oaht_pkg::SIZE_W-1:0]        cfg_wdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [oaht_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire oaht_pkg::dp_cmd_t                  cmd,
  output oaht_pkg::dp_sts_t                       sts
);

  localparam int SW = oaht_pkg::SIZE_W;
  localparam int AW = oaht_pkg::ADDR_W;

  // configuration
  logic [SW-1:0] tsize_r;
  logic [1:0]    strat_r;
  logic [SW-1:0] sz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= SW'(oaht_pkg::TABLE_DEPTH);
      strat_r <= oaht_pkg::STRAT_LINEAR;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        oaht_pkg::REG_TABLE_SIZE:     tsize_r <= cfg_wdata;
        oaht_pkg::REG_PROBE_STRATEGY: strat_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tsize_r == '0) sz = SW'(1);
    else if (tsize_r > SW'(oaht_pkg::TABLE_DEPTH)) sz = SW'(oaht_pkg::TABLE_DEPTH);
    else sz = tsize_r;
  end

  // request capture
  logic [1:0]                   in_op;
  logic [oaht_pkg::KEY_W-1:0]   in_key;
  logic [oaht_pkg::MAG_W-1:0]   in_mag;
  assign in_op  = in_tdata[1:0];
  assign in_key = in_tdata[2 +: oaht_pkg::KEY_W];
  assign in_mag = in_key[oaht_pkg::KEY_W-1] ? (~in_key + 1'b1) : in_key;

  logic [1:0]                  op_r, strat_q_r;
  logic [oaht_pkg::KEY_W-1:0]  key_r;
  logic                        neg_r;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_r      <= in_op;
      key_r     <= in_key;
      neg_r     <= in_key[oaht_pkg::KEY_W-1];
      strat_q_r <= strat_r;
    end
  end

  // digit reversal, a multiply state and an accumulate state per decimal digit
  logic [oaht_pkg::MAG_W-1:0]  mag_r;
  logic [oaht_pkg::PROD_W-1:0] prod_r;
  logic [oaht_pkg::REV_W-1:0]  rev_r;
  logic [oaht_pkg::MAG_W-1:0]  quo;
  logic [oaht_pkg::MAG_W+3:0]  quo10;
  logic [oaht_pkg::MAG_W+3:0]  diff;
  logic [3:0]                  digit;

  assign quo   = oaht_pkg::MAG_W'(prod_r[oaht_pkg::PROD_W-1:oaht_pkg::RECIP_SHIFT]);
  assign quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign diff  = {4'b0000, mag_r} - quo10;
  assign digit = diff[3:0];

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      mag_r <= in_mag;
      rev_r <= '0;
    end else if (cmd.racc) begin
      mag_r <= quo;
      rev_r <= {rev_r[oaht_pkg::REV_W-4:0], 3'b000} + {rev_r[oaht_pkg::REV_W-2:0], 1'b0}
             + oaht_pkg::REV_W'(digit);
    end
    if (cmd.rmul) begin
      prod_r <= oaht_pkg::PROD_W'(mag_r) * oaht_pkg::PROD_W'(oaht_pkg::RECIP);
    end
  end

  // restoring remainder unit, one dividend bit per cycle
  logic [oaht_pkg::REV_W-1:0]  div_r;
  logic [oaht_pkg::MCNT_W-1:0] mcnt_r;
  logic [SW-1:0]               rem_r;
  logic [SW:0]                 trial;
  logic [SW-1:0]               modv;
  logic [SW-1:0]               keym_r, revm_r;

  assign trial = {rem_r, div_r[oaht_pkg::REV_W-1]};
  assign modv  = (neg_r && rem_r != '0) ? (sz - rem_r) : rem_r;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      div_r  <= oaht_pkg::REV_W'(in_mag);
      mcnt_r <= oaht_pkg::MCNT_W'(oaht_pkg::REV_W);
      rem_r  <= '0;
    end else if (cmd.rmod_load) begin
      div_r  <= rev_r;
      mcnt_r <= oaht_pkg::MCNT_W'(oaht_pkg::REV_W);
      rem_r  <= '0;
    end else if (cmd.mod_step) begin
      div_r  <= {div_r[oaht_pkg::REV_W-2:0], 1'b0};
      mcnt_r <= mcnt_r - 1'b1;
      rem_r  <= (trial >= {1'b0, sz}) ? SW'(trial - {1'b0, sz}) : SW'(trial);
    end
    if (cmd.kfin) keym_r <= modv;
    if (cmd.rfin) revm_r <= modv;
  end

  // probe walk
  logic [SW-1:0]             pos_r, inc_r, cnt_r;
  logic                      ok_r;
  logic [SW:0]               pos_sum, inc_sum;
  logic [SW-1:0]             pos_nxt, inc_nxt, step0;
  logic [oaht_pkg::RAM_W-1:0] rdata;
  logic [oaht_pkg::MARK_W-1:0] smark;
  logic [oaht_pkg::KEY_W-1:0] skey;
  logic                      key_eq;
  logic                      p_we, p_ok, p_stop;
  logic [oaht_pkg::MARK_W-1:0] p_mark;

  assign step0   = (sz == SW'(1)) ? '0 : SW'(1);
  assign pos_sum = {1'b0, pos_r} + {1'b0, inc_r};
  assign pos_nxt = (pos_sum >= {1'b0, sz}) ? SW'(pos_sum - {1'b0, sz}) : SW'(pos_sum);
  assign inc_sum = {1'b0, inc_r} + (SW + 1)'(2);

  always_comb begin
    if (sz == SW'(1)) inc_nxt = '0;
    else if (inc_sum >= {1'b0, sz}) inc_nxt = SW'(inc_sum - {1'b0, sz});
    else inc_nxt = SW'(inc_sum);
  end

  assign smark  = rdata[oaht_pkg::RAM_W-1 -: oaht_pkg::MARK_W];
  assign skey   = rdata[oaht_pkg::KEY_W-1:0];
  assign key_eq = (skey == key_r);

  always_comb begin
    p_we   = 1'b0;
    p_ok   = 1'b0;
    p_stop = 1'b0;
    p_mark = oaht_pkg::MARK_FULL;
    case (op_r)
      oaht_pkg::OP_INSERT: begin
        if (smark == oaht_pkg::MARK_EMPTY) begin
          p_we = 1'b1; p_ok = 1'b1; p_stop = 1'b1;
        end else if (key_eq) begin
          p_stop = 1'b1;
          if (smark == oaht_pkg::MARK_DELETED) begin
            p_we = 1'b1; p_ok = 1'b1;
          end
        end
      end
      oaht_pkg::OP_REMOVE, oaht_pkg::OP_SEARCH: begin
        if (smark == oaht_pkg::MARK_FULL && key_eq) begin
          p_ok = 1'b1; p_stop = 1'b1;
          if (op_r == oaht_pkg::OP_REMOVE) begin
            p_we   = 1'b1;
            p_mark = oaht_pkg::MARK_DELETED;
          end
        end else if (smark == oaht_pkg::MARK_EMPTY) begin
          p_stop = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      cnt_r <= '0;
      ok_r  <= 1'b0;
    end else if (cmd.probe_init) begin
      pos_r <= keym_r;
      cnt_r <= '0;
      inc_r <= (strat_q_r == oaht_pkg::STRAT_DOUBLE) ? revm_r : step0;
    end else if (cmd.probe_chk) begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_r + 1'b1;
      ok_r  <= p_ok;
      if (strat_q_r == oaht_pkg::STRAT_QUAD) inc_r <= inc_nxt;
    end
  end

  // clearing sweep after reset
  logic [AW-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [oaht_pkg::RAM_W-1:0] wdata;

  always_comb begin
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = {oaht_pkg::MARK_EMPTY, {oaht_pkg::KEY_W{1'b0}}};
    end else begin
      we    = cmd.probe_chk && p_we;
      waddr = pos_r[AW-1:0];
      wdata = {p_mark, key_r};
    end
  end

  oaht_ram #(
    .WIDTH (oaht_pkg::RAM_W),
    .DEPTH (oaht_pkg::TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos_r[AW-1:0]),
    .rdata (rdata)
  );

  // output register
  logic                             out_valid_r;
  logic [oaht_pkg::OUT_DATA_W-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.result_load) begin
      out_data_r <= {4'b0000,
                     (op_r == oaht_pkg::OP_SEARCH) ? cnt_r : {SW{1'b0}},
                     ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.clr_last   = (clr_cnt_r == AW'(oaht_pkg::TABLE_DEPTH - 1));
  assign sts.mod_done   = (mcnt_r == '0);
  assign sts.mag_zero   = (mag_r == '0);
  assign sts.op_ignore  = (op_r == oaht_pkg::OP_NONE);
  assign sts.strat_dbl  = (strat_q_r == oaht_pkg::STRAT_DOUBLE);
  assign sts.probe_stop = p_stop;
  assign sts.probe_last = ({1'b0, cnt_r} + 1'b1) == {1'b0, sz};
  assign sts.out_busy   = out_valid_r && !out_tready;

endmodule
`default_nettype wire

[hdl/open_addressing_hash_table.sv]
// open_addressing_hash_table: top level, joins controller and datapath
// depends on oaht_pkg, oaht_ctrl, oaht_dp (and oaht_ram below it)
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_      | slave     | tdata: req_type[1:0], key_value[32:2], zero pad
//   out_     | master    | tdata: success[0], probe_count[11:1], zero pad
//   cfg_     | write     | addr 0 table_size, addr 1 probe_strategy
//
// one transaction at a time; from accept to result the remainder unit works
// out key mod size (34 bit steps and a done state), and each probe needs
// a registered slot ram read and a check; double hashing adds a multiply
// and an accumulate state per key digit and a second remainder run for the step
// after reset a sweep marks every one of the 1024 slots empty; in_tready stays low
// a finished result waits in the output register, the next transaction
// is taken meanwhile and only stalls at its own end
`default_nettype none
module open_addressing_hash_table (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [oaht_pkg::IN_DATA_W-1:0]      in_tdata,   // req_type, key_value
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [oaht_pkg::OUT_DATA_W-1:0]     out_tdata,  // success, probe_count
  input  wire logic                                cfg_wr_en,
  input  wire logic                                cfg_addr,
  input  wire logic [oaht_pkg::SIZE_W-1:0]         cfg_wdata
);

  oaht_pkg::dp_cmd_t cmd;
  oaht_pkg::dp_sts_t sts;

  // sequencing
  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, slot store and result register
  oaht_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

[hdl/oaht_chk.sv]
// oaht_chk: port level checks of the hash table, bound to the top level
// depends on oaht_pkg
`default_nettype none
module oaht_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [oaht_pkg::OUT_DATA_W-1:0] out_tdata
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // one transaction in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // probe count never above depth, padding zero
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:1] <= 11'(oaht_pkg::TABLE_DEPTH)
                   && out_tdata[15:12] == 4'b0000)
    else $error("probe count out of range");

  // input held off while the clearing sweep starts after reset
  a_no_ready_in_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during clearing sweep");

endmodule

bind open_addressing_hash_table oaht_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[tb/open_addressing_hash_table_tb.sv]
// open_addressing_hash_table_tb: self-checking testbench for the hash table
// depends on oaht_pkg and open_addressing_hash_table; stand-alone otherwise
`timescale 1ns / 1ps

typedef struct {
  bit        found;
  bit [10:0] probes;
} lookup_result_t;

// keeps a shadow copy of the table and the expected results in order
class hash_scoreboard;
  int unsigned    tbl_size = oaht_pkg::TABLE_DEPTH;
  bit [1:0]       strategy = oaht_pkg::STRAT_LINEAR;
  int             slot_key  [oaht_pkg::TABLE_DEPTH];
  bit [1:0]       slot_mark [oaht_pkg::TABLE_DEPTH];
  lookup_result_t pending[$];
  int             errors = 0;

  function new();
    foreach (slot_mark[i]) slot_mark[i] = oaht_pkg::MARK_EMPTY;
  endfunction

  function int unsigned probe_index(longint k, longint rev, longint i, longint sz);
    longint step;
    longint idx;
    case (strategy)
      oaht_pkg::STRAT_QUAD:   step = i * i;
      oaht_pkg::STRAT_DOUBLE: step = i * rev;
      default:                step = i;
    endcase
    idx = (k + step) % sz;
    if (idx < 0) idx += sz;
    return int'(idx) % oaht_pkg::TABLE_DEPTH;
  endfunction

  // accepted request: run it against the shadow table, queue the answer
  function void note_request(bit [1:0] op, bit signed [30:0] key);
    longint         k;
    longint         m;
    longint         rev;
    int unsigned    sz;
    int unsigned    s;
    lookup_result_t r;
    k = longint'(key);
    m = (k < 0) ? -k : k;
    rev = 0;
    while (m != 0) begin
      rev = rev * 10 + m % 10;
      m = m / 10;
    end
    if (k < 0) rev = -rev;
    sz = (tbl_size < 1) ? 1 :
         (tbl_size > oaht_pkg::TABLE_DEPTH) ? oaht_pkg::TABLE_DEPTH : tbl_size;
    r.found = 0;
    r.probes = 0;
    if (op == oaht_pkg::OP_INSERT) begin
      for (int i = 0; i < sz; i++) begin
        s = probe_index(k, rev, i, sz);
        if (slot_mark[s] == oaht_pkg::MARK_EMPTY) begin
          slot_mark[s] = oaht_pkg::MARK_FULL;
          slot_key[s] = int'(k);
          r.found = 1;
          break;
        end
        if (slot_key[s] == int'(k)) begin
          // a tombstone of the same key comes back to life
          if (slot_mark[s] == oaht_pkg::MARK_DELETED) begin
            slot_mark[s] = oaht_pkg::MARK_FULL;
            r.found = 1;
          end
          break;
        end
      end
    end else if (op == oaht_pkg::OP_REMOVE || op == oaht_pkg::OP_SEARCH) begin
      for (int i = 0; i < sz; i++) begin
        s = probe_index(k, rev, i, sz);
        r.probes++;
        if (slot_mark[s] == oaht_pkg::MARK_FULL && slot_key[s] == int'(k)) begin
          if (op == oaht_pkg::OP_REMOVE) slot_mark[s] = oaht_pkg::MARK_DELETED;
          r.found = 1;
          break;
        end
        if (slot_mark[s] == oaht_pkg::MARK_EMPTY) break;
      end
      if (op == oaht_pkg::OP_REMOVE) r.probes = 0;
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [oaht_pkg::OUT_DATA_W-1:0] data);
    lookup_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transaction %h", data);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (data[0] !== e.found) begin
      $error("success: expected %0d, got %0d", e.found, data[0]);
      errors++;
    end
    if (data[11:1] !== e.probes) begin
      $error("probe_count: expected %0d, got %0d", e.probes, data[11:1]);
      errors++;
    end
  endfunction
endclass

module open_addressing_hash_table_tb;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [oaht_pkg::IN_DATA_W-1:0]  in_tdata;    // req_type[1:0], key_value[32:2], zero pad
  logic                            out_tvalid;
  logic                            out_tready;
  logic [oaht_pkg::OUT_DATA_W-1:0] out_tdata;   // success[0], probe_count[11:1], zero pad
  logic                            cfg_wr_en;
  logic                            cfg_addr;
  logic [oaht_pkg::SIZE_W-1:0]     cfg_wdata;

  hash_scoreboard sb = new();

  // receiver behaviour, steered by the main sequence
  bit no_gaps   = 0;
  bit long_hold = 0;

  open_addressing_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // safety net: the slowest correct run is far below this
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result monitor: one check per accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random back-pressure, and one very long stall when asked
  initial begin
    int gap;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // offer one request; valid stays high between back-to-back requests
  task automatic send_request(bit [1:0] op, bit signed [30:0] key);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {7'd0, key, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, key);
  endtask

  // wait until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [oaht_pkg::SIZE_W-1:0] value);
    cfg_wr_en <= 1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (addr == oaht_pkg::REG_TABLE_SIZE) sb.tbl_size = value;
    else sb.strategy = value[1:0];
    @(posedge clk);
  endtask

  // keys mostly from a small pool so that hits, duplicates and chains occur
  function automatic bit signed [30:0] pick_key(int pool);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 31'($urandom());
    if (sel == 1) return 31'(-$urandom_range(0, pool));
    if (sel == 2) return 31'(999999999 - $urandom_range(0, pool));
    return 31'($urandom_range(0, pool));
  endfunction

  function automatic bit [1:0] pick_op();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return oaht_pkg::OP_INSERT;
    if (sel < 65) return oaht_pkg::OP_REMOVE;
    if (sel < 95) return oaht_pkg::OP_SEARCH;
    return oaht_pkg::OP_NONE;
  endfunction

  localparam int N_PHASES = 8;
  int phase_size  [N_PHASES] = '{1024, 7, 2047, 0, 13, 64, 1, 100};
  int phase_strat [N_PHASES] = '{oaht_pkg::STRAT_DOUBLE, oaht_pkg::STRAT_QUAD,
                                 oaht_pkg::STRAT_LINEAR, 3,
                                 oaht_pkg::STRAT_DOUBLE, oaht_pkg::STRAT_QUAD,
                                 oaht_pkg::STRAT_LINEAR, oaht_pkg::STRAT_DOUBLE};

  initial begin
    int pool;
    in_tvalid = 0;
    in_tdata  = '0;
    cfg_wr_en = 0;
    cfg_addr  = oaht_pkg::REG_TABLE_SIZE;
    cfg_wdata = '0;
    rst_n     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: key extremes, every operation, tombstone revival, op three
    send_request(oaht_pkg::OP_INSERT, 31'sd0);
    send_request(oaht_pkg::OP_INSERT, -31'sd1);
    send_request(oaht_pkg::OP_INSERT, 31'sh3FFF_FFFF);
    send_request(oaht_pkg::OP_INSERT, 31'sh4000_0000);
    send_request(oaht_pkg::OP_INSERT, 31'sd999999999);
    send_request(oaht_pkg::OP_INSERT, -31'sd999999999);
    send_request(oaht_pkg::OP_INSERT, 31'sd999999999);   // duplicate
    send_request(oaht_pkg::OP_SEARCH, 31'sh4000_0000);
    send_request(oaht_pkg::OP_SEARCH, 31'sd1023);        // collides with -1 mod 1024
    send_request(oaht_pkg::OP_REMOVE, -31'sd1);
    send_request(oaht_pkg::OP_SEARCH, -31'sd1);
    send_request(oaht_pkg::OP_REMOVE, -31'sd1);          // already a tombstone
    send_request(oaht_pkg::OP_INSERT, -31'sd1);          // revived
    send_request(oaht_pkg::OP_SEARCH, -31'sd1);
    send_request(oaht_pkg::OP_NONE, 31'sd5);
    drain();
    // size zero acts as one slot, strategy three as linear
    write_reg(oaht_pkg::REG_TABLE_SIZE, 11'd0);
    write_reg(oaht_pkg::REG_PROBE_STRATEGY, 11'd3);
    send_request(oaht_pkg::OP_INSERT, 31'sd77);          // slot 0 already taken
    send_request(oaht_pkg::OP_SEARCH, 31'sd77);
    send_request(oaht_pkg::OP_SEARCH, 31'sd0);
    drain();
    // resize back up: contents stay
    write_reg(oaht_pkg::REG_TABLE_SIZE, 11'd1024);
    send_request(oaht_pkg::OP_SEARCH, 31'sd999999999);
    drain();

    // random phases over several settings
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(oaht_pkg::REG_TABLE_SIZE, oaht_pkg::SIZE_W'(phase_size[p]));
      write_reg(oaht_pkg::REG_PROBE_STRATEGY, oaht_pkg::SIZE_W'(phase_strat[p]));
      pool = (phase_size[p] < 2) ? 4 : 3 * ((phase_size[p] > 1024) ? 1024 : phase_size[p]);
      if (p == 1) long_hold = 1;   // input backs up behind a stalled output
      for (int n = 0; n < 215; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        send_request(pick_op(), pick_key(pool));
        if (n == 120) drain();     // sender waits for every result
      end
      drain();
    end

    no_gaps = 0;
    drain();
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
hdl/oaht_pkg.sv
hdl/oaht_ram.sv
hdl/oaht_ctrl.sv
hdl/oaht_dp.sv
hdl/open_addressing_hash_table.sv
hdl/oaht_chk.sv
tb/open_addressing_hash_table_tb.sv
